[rtl/core/hkdr_pkg.sv]
// shared types, codes and constants of the hex keypad data-ready controller
package hkdr_pkg;

  // event codes carried by the kind field
  localparam logic [2:0] KIND_KEY_DOWN  = 3'd0;
  localparam logic [2:0] KIND_KEY_UP    = 3'd1;
  localparam logic [2:0] KIND_TICK      = 3'd2;
  localparam logic [2:0] KIND_SET_MODE  = 3'd3;
  localparam logic [2:0] KIND_READ_DATA = 3'd4;
  localparam logic [2:0] KIND_READ_COIN = 3'd5;
  localparam logic [2:0] KIND_PRESET    = 3'd6;

  // keypad modes; the unused code behaves as byte mode
  localparam logic [1:0] MODE_HEX       = 2'd0;
  localparam logic [1:0] MODE_BYTE      = 2'd1;
  localparam logic [1:0] MODE_HEX_PULSE = 2'd2;

  // register indexes on the configuration port
  localparam logic [2:0] REG_KEY_MODE    = 3'd0;
  localparam logic [2:0] REG_DATA_MODE   = 3'd1;
  localparam logic [2:0] REG_DIRECT_MODE = 3'd2;
  localparam logic [2:0] REG_ARCADE      = 3'd3;
  localparam logic [2:0] REG_FLAG_INVERT = 3'd4;
  localparam logic [2:0] REG_HOLD_TICKS  = 3'd5;
  localparam logic [2:0] REG_PULSE_TICKS = 3'd6;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // reset values
  localparam logic [1:0]  RST_DATA_MODE   = 2'd1;
  localparam logic [1:0]  RST_DIRECT_MODE = 2'd2;
  localparam logic [15:0] RST_HOLD_TICKS  = 16'd20000;
  localparam logic [15:0] RST_PULSE_TICKS = 16'd2000;

  typedef struct packed {
    logic [1:0]  key_mode;
    logic [1:0]  data_mode_code;
    logic [1:0]  direct_mode_code;
    logic        arcade_enable;
    logic [2:0]  flag_invert;
    logic [15:0] hold_ticks;
    logic [15:0] pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] key_index;
    logic       hex_key;
    logic       shift_key;
    logic       coin_key;
    logic [7:0] dir_mask;
    logic       fire_a_key;
    logic       fire_b_key;
    logic       still_held;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic       ef_data;
    logic       ef_fire_b;
    logic       ef_coin;
    logic [7:0] read_data;
    logic       dma_valid;
    logic [7:0] dma_data;
  } result_t;

endpackage

[rtl/core/hkdr_cfg.sv]
// configuration register file behind the apb-style port
module hkdr_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hkdr_pkg::ADDR_W-1:0] paddr,
  input  logic [hkdr_pkg::DATA_W-1:0] pwdata,
  output logic [hkdr_pkg::DATA_W-1:0] prdata,
  output hkdr_pkg::cfg_t              cfg
);
  import hkdr_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.key_mode         <= MODE_HEX;
      cfg_q.data_mode_code   <= RST_DATA_MODE;
      cfg_q.direct_mode_code <= RST_DIRECT_MODE;
      cfg_q.arcade_enable    <= 1'b0;
      cfg_q.flag_invert      <= 3'd0;
      cfg_q.hold_ticks       <= RST_HOLD_TICKS;
      cfg_q.pulse_ticks      <= RST_PULSE_TICKS;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_MODE:    cfg_q.key_mode         <= pwdata[1:0];
        REG_DATA_MODE:   cfg_q.data_mode_code   <= pwdata[1:0];
        REG_DIRECT_MODE: cfg_q.direct_mode_code <= pwdata[1:0];
        REG_ARCADE:      cfg_q.arcade_enable    <= pwdata[0];
        REG_FLAG_INVERT: cfg_q.flag_invert      <= pwdata[2:0];
        REG_HOLD_TICKS:  cfg_q.hold_ticks       <= pwdata[15:0];
        REG_PULSE_TICKS: cfg_q.pulse_ticks      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_KEY_MODE:    prdata = {30'd0, cfg_q.key_mode};
      REG_DATA_MODE:   prdata = {30'd0, cfg_q.data_mode_code};
      REG_DIRECT_MODE: prdata = {30'd0, cfg_q.direct_mode_code};
      REG_ARCADE:      prdata = {31'd0, cfg_q.arcade_enable};
      REG_FLAG_INVERT: prdata = {29'd0, cfg_q.flag_invert};
      REG_HOLD_TICKS:  prdata = {16'd0, cfg_q.hold_ticks};
      REG_PULSE_TICKS: prdata = {16'd0, cfg_q.pulse_ticks};
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_q;

endmodule

[rtl/core/hkdr_engine.sv]
// keypad state registers and the per-event update and flag logic
module hkdr_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  hkdr_pkg::cfg_t    cfg,
  input  hkdr_pkg::item_t   item,
  output hkdr_pkg::result_t res
);
  import hkdr_pkg::*;

  logic        shift_held, shift_held_next;
  logic [7:0]  key_value, key_value_next;
  logic        ready_flag_n, ready_flag_n_next;
  logic        low_nybble_next, low_nybble_next_next;
  logic        held_valid, held_valid_next;
  logic [15:0] countdown, countdown_next;
  logic [1:0]  port_mode, port_mode_next;
  logic [7:0]  dir_bits, dir_bits_next;
  logic        fire_a_n, fire_a_n_next;
  logic        fire_b_n, fire_b_n_next;
  logic        coin_n, coin_n_next;

  always_comb begin
    logic        direct;
    logic        hex_like;
    logic [7:0]  rd;
    logic        dv;
    logic [7:0]  dd;
    direct   = (port_mode == cfg.direct_mode_code);
    hex_like = (cfg.key_mode == MODE_HEX) || (cfg.key_mode == MODE_HEX_PULSE);
    rd = '0;
    dv = 1'b0;
    dd = '0;
    shift_held_next      = shift_held;
    key_value_next       = key_value;
    ready_flag_n_next    = ready_flag_n;
    low_nybble_next_next = low_nybble_next;
    held_valid_next      = held_valid;
    countdown_next       = countdown;
    port_mode_next       = port_mode;
    dir_bits_next        = dir_bits;
    fire_a_n_next        = fire_a_n;
    fire_b_n_next        = fire_b_n;
    coin_n_next          = coin_n;

    unique case (item.kind)
      KIND_KEY_DOWN: begin
        if (item.shift_key) begin
          shift_held_next = 1'b1;
        end
        if (item.hex_key) begin
          held_valid_next = 1'b1;
          countdown_next = (cfg.key_mode == MODE_HEX_PULSE) ? cfg.pulse_ticks
                                                             : cfg.hold_ticks;
          if (hex_like) begin
            if (direct) begin
              dv = 1'b1;
              dd = {3'd0, shift_held_next, item.key_index};
            end else begin
              key_value_next    = {3'd0, shift_held_next, item.key_index};
              ready_flag_n_next = 1'b0;
            end
          end else if (!low_nybble_next) begin
            low_nybble_next_next = 1'b1;
            key_value_next       = {item.key_index, 4'd0};
          end else begin
            low_nybble_next_next = 1'b0;
            if (direct) begin
              dv = 1'b1;
              dd = key_value | {4'd0, item.key_index};
            end else begin
              key_value_next    = key_value | {4'd0, item.key_index};
              ready_flag_n_next = 1'b0;
            end
          end
        end
        // mark dropped while no data is pending
        if (ready_flag_n_next) begin
          held_valid_next = 1'b0;
        end
        if (cfg.arcade_enable) begin
          if (item.coin_key) begin
            coin_n_next = 1'b0;
          end
          dir_bits_next = dir_bits | item.dir_mask;
          if (item.fire_a_key) begin
            fire_a_n_next = 1'b0;
          end
          if (item.fire_b_key) begin
            fire_b_n_next = 1'b0;
          end
        end
      end
      KIND_KEY_UP: begin
        if (item.shift_key) begin
          shift_held_next = 1'b0;
        end else begin
          ready_flag_n_next = 1'b1;
        end
        if (cfg.arcade_enable) begin
          dir_bits_next = dir_bits & ~item.dir_mask;
          if (item.fire_a_key) begin
            fire_a_n_next = 1'b1;
          end
          if (item.fire_b_key) begin
            fire_b_n_next = 1'b1;
          end
        end
      end
      KIND_TICK: begin
        if (countdown != 16'd0) begin
          countdown_next = countdown - 16'd1;
        end else if (cfg.key_mode == MODE_HEX_PULSE) begin
          ready_flag_n_next = 1'b1;
          countdown_next    = cfg.pulse_ticks;
        end else if (held_valid) begin
          ready_flag_n_next = !item.still_held;
          countdown_next    = cfg.hold_ticks;
        end
      end
      KIND_SET_MODE: begin
        port_mode_next = item.value[1:0];
      end
      KIND_READ_DATA: begin
        ready_flag_n_next = 1'b1;
        rd = key_value;
      end
      KIND_READ_COIN: begin
        coin_n_next = 1'b1;
        rd = dir_bits;
      end
      KIND_PRESET: begin
        key_value_next    = item.value;
        ready_flag_n_next = 1'b0;
      end
      default: ;
    endcase

    if (port_mode_next == cfg.data_mode_code) begin
      res.ef_data = ready_flag_n_next ^ cfg.flag_invert[0];
    end else if (cfg.arcade_enable) begin
      res.ef_data = fire_a_n_next ^ cfg.flag_invert[0];
    end else begin
      res.ef_data = 1'b1;
    end
    res.ef_fire_b = cfg.arcade_enable ? (fire_b_n_next ^ cfg.flag_invert[1]) : 1'b1;
    res.ef_coin   = coin_n_next ^ cfg.flag_invert[2];
    res.read_data = rd;
    res.dma_valid = dv;
    res.dma_data  = dd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held      <= 1'b0;
      key_value       <= 8'd0;
      ready_flag_n    <= 1'b1;
      low_nybble_next <= 1'b0;
      held_valid      <= 1'b0;
      countdown       <= RST_HOLD_TICKS;
      port_mode       <= 2'd0;
      dir_bits        <= 8'd0;
      fire_a_n        <= 1'b1;
      fire_b_n        <= 1'b1;
      coin_n          <= 1'b1;
    end else if (fire) begin
      shift_held      <= shift_held_next;
      key_value       <= key_value_next;
      ready_flag_n    <= ready_flag_n_next;
      low_nybble_next <= low_nybble_next_next;
      held_valid      <= held_valid_next;
      countdown       <= countdown_next;
      port_mode       <= port_mode_next;
      dir_bits        <= dir_bits_next;
      fire_a_n        <= fire_a_n_next;
      fire_b_n        <= fire_b_n_next;
      coin_n          <= coin_n_next;
    end
  end

endmodule

[rtl/core/hex_keypad_data_ready_controller_top.sv]
// top level of the hex keypad data-ready controller: handshakes, stage registers, config
// The controller takes one keypad event per transaction and returns one result
// per event: the three EF flags after inversion, the read data byte and the
// direct (DMA) key output. An accepted event is registered in the input stage,
// where the state update and flag logic run, and its result is then held in an
// output register until taken. Result valid is set when the event leaves the
// input stage, which can wait while the output register is still full, and a
// new event can be accepted every cycle; item_ready only drops when the input
// stage is full and the output register is still waiting on result_ready.
// Configuration is an apb-style register port with seven 32-bit
// registers at byte addresses 0 to 24; pready is always high, and registers
// should only be written while no event is in flight.
module hex_keypad_data_ready_controller_top (
  input  logic                        clk,
  input  logic                        rst,
  // event channel
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [2:0]                  kind,
  input  logic [3:0]                  key_index,
  input  logic                        hex_key,
  input  logic                        shift_key,
  input  logic                        coin_key,
  input  logic [7:0]                  dir_mask,
  input  logic                        fire_a_key,
  input  logic                        fire_b_key,
  input  logic                        still_held,
  input  logic [7:0]                  value,
  // result channel
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        ef_data,
  output logic                        ef_fire_b,
  output logic                        ef_coin,
  output logic [7:0]                  read_data,
  output logic                        dma_valid,
  output logic [7:0]                  dma_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hkdr_pkg::ADDR_W-1:0] paddr,
  input  logic [hkdr_pkg::DATA_W-1:0] pwdata,
  output logic [hkdr_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import hkdr_pkg::*;

  cfg_t    cfg;
  item_t   stage_item;
  logic    stage_valid;
  result_t stage_res;
  result_t out_res;
  logic    advance;
  logic    item_take;

  assign pready = 1'b1;

  hkdr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // input stage moves on when the output register is free or being emptied
  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;
  assign item_take  = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  // payload of the input stage, no reset needed
  always_ff @(posedge clk) begin
    if (item_take) begin
      stage_item.kind       <= kind;
      stage_item.key_index  <= key_index;
      stage_item.hex_key    <= hex_key;
      stage_item.shift_key  <= shift_key;
      stage_item.coin_key   <= coin_key;
      stage_item.dir_mask   <= dir_mask;
      stage_item.fire_a_key <= fire_a_key;
      stage_item.fire_b_key <= fire_b_key;
      stage_item.still_held <= still_held;
      stage_item.value      <= value;
    end
  end

  // state update happens exactly when the event leaves the input stage
  hkdr_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .cfg  (cfg),
    .item (stage_item),
    .res  (stage_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= stage_res;
    end
  end

  assign ef_data   = out_res.ef_data;
  assign ef_fire_b = out_res.ef_fire_b;
  assign ef_coin   = out_res.ef_coin;
  assign read_data = out_res.read_data;
  assign dma_valid = out_res.dma_valid;
  assign dma_data  = out_res.dma_data;

`ifndef SYNTHESIS
  // an accepted event always lands in the input stage
  a_take_fills_stage: assert property (@(posedge clk) disable iff (rst)
    item_take |=> stage_valid)
    else $error("accepted transaction missing from input stage");

  // a blocked input stage keeps its event
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> (stage_valid && $stable(stage_item)))
    else $error("input stage lost a blocked transaction");

  // no dma payload without dma valid
  a_dma_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !dma_valid) |-> (dma_data == 8'd0))
    else $error("dma data set without dma valid");

  // nothing is in flight right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!stage_valid && !result_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

[verif/testbench.sv]
// self-checking testbench for the hex keypad data-ready controller
module testbench;
  import hkdr_pkg::*;

  // kind code that the block does not define; it must leave the state alone
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  // or-ed into a hex key value while shift is down
  localparam logic [7:0] SHIFT_BIT = 8'h10;
  // rough number of events per random phase
  localparam int PHASE_ITEMS = 110;
  localparam int RANDOM_PHASES = 10;
  // receiver hold-off that backs the block up into its input
  localparam int LONG_HOLD_CYCLES = 150;
  // bits in one event
  localparam int ITEM_W = $bits(item_t);

  // clock, reset and dut ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [2:0]  kind = '0;
  logic [3:0]  key_index = '0;
  logic        hex_key = 1'b0;
  logic        shift_key = 1'b0;
  logic        coin_key = 1'b0;
  logic [7:0]  dir_mask = '0;
  logic        fire_a_key = 1'b0;
  logic        fire_b_key = 1'b0;
  logic        still_held = 1'b0;
  logic [7:0]  value = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        ef_data;
  logic        ef_fire_b;
  logic        ef_coin;
  logic [7:0]  read_data;
  logic        dma_valid;
  logic [7:0]  dma_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic        pready;

  hex_keypad_data_ready_controller_top dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .kind(kind), .key_index(key_index), .hex_key(hex_key), .shift_key(shift_key),
    .coin_key(coin_key), .dir_mask(dir_mask), .fire_a_key(fire_a_key),
    .fire_b_key(fire_b_key), .still_held(still_held), .value(value),
    .result_valid(result_valid), .result_ready(result_ready),
    .ef_data(ef_data), .ef_fire_b(ef_fire_b), .ef_coin(ef_coin),
    .read_data(read_data), .dma_valid(dma_valid), .dma_data(dma_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 12 unit period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // events waiting for the driver and results the block still owes
  item_t   keypad_events[$];
  result_t results_due[$];
  int      queued = 0;
  int      results_seen = 0;
  int      fail_count = 0;

  // event currently offered and whether it was taken at the last rising edge
  item_t   on_offer = '0;
  logic    offer_taken = 1'b0;

  // shadow of the configuration registers
  cfg_t    cfg;

  // shadow of the keypad state
  logic        shift_down = 1'b0;
  logic [7:0]  latched_key = '0;
  logic        no_data = 1'b1;
  logic        want_low_nybble = 1'b0;
  logic        tracking_key = 1'b0;
  logic [15:0] poll_count = RST_HOLD_TICKS;
  logic [1:0]  cur_port_mode = '0;
  logic [7:0]  dir_state = '0;
  logic        fire_a_up = 1'b1;
  logic        fire_b_up = 1'b1;
  logic        coin_up = 1'b1;

  // apply one event to the shadow state and return the result it should give
  function automatic result_t advance_keypad(item_t ev);
    result_t    r;
    logic       direct;
    logic       finished;
    logic [7:0] key_byte;
    r = '0;
    finished = 1'b0;
    key_byte = '0;
    direct = (cur_port_mode == cfg.direct_mode_code);
    case (ev.kind)
      KIND_KEY_DOWN: begin
        if (ev.shift_key) shift_down = 1'b1;
        if (ev.hex_key) begin
          tracking_key = 1'b1;
          poll_count = (cfg.key_mode == MODE_HEX_PULSE) ? cfg.pulse_ticks : cfg.hold_ticks;
          if (cfg.key_mode == MODE_HEX || cfg.key_mode == MODE_HEX_PULSE) begin
            key_byte = {4'h0, ev.key_index} | (shift_down ? SHIFT_BIT : 8'h00);
            finished = 1'b1;
          end else if (!want_low_nybble) begin
            // byte mode, high nybble first
            want_low_nybble = 1'b1;
            latched_key = {ev.key_index, 4'h0};
          end else begin
            want_low_nybble = 1'b0;
            key_byte = latched_key | {4'h0, ev.key_index};
            finished = 1'b1;
          end
          // a finished value goes out as dma in direct mode, else it is latched
          if (finished && direct) begin
            r.dma_valid = 1'b1;
            r.dma_data = key_byte;
          end else if (finished) begin
            latched_key = key_byte;
            no_data = 1'b0;
          end
        end
        // held key is only tracked while data is pending
        if (no_data) tracking_key = 1'b0;
        if (cfg.arcade_enable) begin
          if (ev.coin_key) coin_up = 1'b0;
          dir_state = dir_state | ev.dir_mask;
          if (ev.fire_a_key) fire_a_up = 1'b0;
          if (ev.fire_b_key) fire_b_up = 1'b0;
        end
      end
      KIND_KEY_UP: begin
        if (ev.shift_key) shift_down = 1'b0;
        else no_data = 1'b1;
        if (cfg.arcade_enable) begin
          dir_state = dir_state & ~ev.dir_mask;
          if (ev.fire_a_key) fire_a_up = 1'b1;
          if (ev.fire_b_key) fire_b_up = 1'b1;
        end
      end
      KIND_TICK: begin
        if (poll_count != 16'd0) begin
          poll_count = poll_count - 16'd1;
        end else if (cfg.key_mode == MODE_HEX_PULSE) begin
          no_data = 1'b1;
          poll_count = cfg.pulse_ticks;
        end else if (tracking_key) begin
          no_data = !ev.still_held;
          poll_count = cfg.hold_ticks;
        end
      end
      KIND_SET_MODE: cur_port_mode = ev.value[1:0];
      KIND_READ_DATA: begin
        no_data = 1'b1;
        r.read_data = latched_key;
      end
      KIND_READ_COIN: begin
        coin_up = 1'b1;
        r.read_data = dir_state;
      end
      KIND_PRESET: begin
        latched_key = ev.value;
        no_data = 1'b0;
      end
      default: ;
    endcase
    // flags show the state after the event
    if (cur_port_mode == cfg.data_mode_code) r.ef_data = no_data ^ cfg.flag_invert[0];
    else if (cfg.arcade_enable) r.ef_data = fire_a_up ^ cfg.flag_invert[0];
    else r.ef_data = 1'b1;
    r.ef_fire_b = cfg.arcade_enable ? (fire_b_up ^ cfg.flag_invert[1]) : 1'b1;
    r.ef_coin = coin_up ^ cfg.flag_invert[2];
    return r;
  endfunction

  function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
      fail_count++;
    end
  endfunction

  // event sender: changes on the falling edge, works in bursts with gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !offer_taken) begin
      // transaction still pending, payload stays put
    end else if (gap_left > 0) begin
      item_valid <= 1'b0;
      gap_left--;
    end else if (keypad_events.size() != 0) begin
      on_offer = keypad_events.pop_front();
      {kind, key_index, hex_key, shift_key, coin_key, dir_mask,
       fire_a_key, fire_b_key, still_held, value} <= on_offer;
      item_valid <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // new burst; about a third of them follow straight on with no gap
        burst_left = $urandom_range(0, 30);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      item_valid <= 1'b0;
    end
  end

  // result receiver: rotating ready pattern plus long hold-offs
  logic [7:0] ready_pat = 8'hFF;
  int         pat_age = 0;
  int         hold_left = 0;
  int         next_hold_at = 300;

  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left--;
    end else if (results_seen >= next_hold_at) begin
      // stop taking results for a while so the block fills and stalls its input
      hold_left = LONG_HOLD_CYCLES;
      next_hold_at += 600;
      result_ready <= 1'b0;
    end else begin
      ready_pat = {ready_pat[0], ready_pat[7:1]};
      pat_age++;
      if (pat_age == 64) begin
        pat_age = 0;
        ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      result_ready <= ready_pat[0];
    end
  end

  // monitor: sample on the rising edge, check results, predict accepted events
  result_t got;
  result_t want;

  always @(posedge clk) begin
    if (rst) begin
      offer_taken = 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        got = {ef_data, ef_fire_b, ef_coin, read_data, dma_valid, dma_data};
        if (results_due.size() == 0) begin
          $display("%0t: result with none expected, got 0x%0h", $time, got);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("ef_data", 8'(want.ef_data), 8'(got.ef_data));
          check_field("ef_fire_b", 8'(want.ef_fire_b), 8'(got.ef_fire_b));
          check_field("ef_coin", 8'(want.ef_coin), 8'(got.ef_coin));
          check_field("read_data", want.read_data, got.read_data);
          check_field("dma_valid", 8'(want.dma_valid), 8'(got.dma_valid));
          check_field("dma_data", want.dma_data, got.dma_data);
        end
        results_seen++;
      end
      offer_taken = item_valid && item_ready;
      if (offer_taken) results_due.push_back(advance_keypad(on_offer));
    end
  end

  function automatic void enqueue(item_t e);
    keypad_events.push_back(e);
    queued++;
  endfunction

  // event of the given kind with every other field random
  function automatic item_t rand_event(logic [2:0] k);
    item_t e;
    e = ITEM_W'($urandom);
    e.kind = k;
    return e;
  endfunction

  // event of the given kind with every other field zero
  function automatic item_t bare_event(logic [2:0] k);
    item_t e;
    e = '0;
    e.kind = k;
    return e;
  endfunction

  // one well-formed use of the keypad: optional mode change, presses with
  // ticks while held, then optional reads and preset; fields not set here stay random
  function automatic void push_session();
    item_t e;
    int    presses;
    logic  with_shift;
    if ($urandom_range(0, 2) == 0) begin
      e = rand_event(KIND_SET_MODE);
      // steer toward the data-ready and direct modes
      case ($urandom_range(0, 2))
        0: e.value[1:0] = cfg.data_mode_code;
        1: e.value[1:0] = cfg.direct_mode_code;
        default: ;
      endcase
      enqueue(e);
    end
    presses = $urandom_range(1, 3);
    repeat (presses) begin
      with_shift = ($urandom_range(0, 3) == 0);
      if (with_shift) begin
        e = rand_event(KIND_KEY_DOWN);
        e.hex_key = 1'b0;
        e.shift_key = 1'b1;
        enqueue(e);
      end
      e = rand_event(KIND_KEY_DOWN);
      e.hex_key = 1'b1;
      e.shift_key = 1'b0;
      enqueue(e);
      repeat ($urandom_range(0, 8)) begin
        e = rand_event(KIND_TICK);
        e.still_held = ($urandom_range(0, 3) != 0);
        enqueue(e);
      end
      e = rand_event(KIND_KEY_UP);
      e.shift_key = ($urandom_range(0, 7) == 0);
      enqueue(e);
      if (with_shift) begin
        e = rand_event(KIND_KEY_UP);
        e.shift_key = 1'b1;
        enqueue(e);
      end
    end
    if ($urandom_range(0, 1) == 0) enqueue(rand_event(KIND_READ_DATA));
    if ($urandom_range(0, 3) == 0) enqueue(rand_event(KIND_READ_COIN));
    if ($urandom_range(0, 5) == 0) enqueue(rand_event(KIND_PRESET));
  endfunction

  // register write: setup cycle, then access cycle until pready
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(REG_KEY_MODE, {30'd0, c.key_mode});
    write_reg(REG_DATA_MODE, {30'd0, c.data_mode_code});
    write_reg(REG_DIRECT_MODE, {30'd0, c.direct_mode_code});
    write_reg(REG_ARCADE, {31'd0, c.arcade_enable});
    write_reg(REG_FLAG_INVERT, {29'd0, c.flag_invert});
    write_reg(REG_HOLD_TICKS, {16'd0, c.hold_ticks});
    write_reg(REG_PULSE_TICKS, {16'd0, c.pulse_ticks});
    cfg = c;
  endtask

  // every event is sent and every result is back
  task automatic wait_drained();
    while (keypad_events.size() != 0 || item_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    cfg_t  nc;
    item_t e;
    int    start;
    cfg = '0;
    cfg.data_mode_code = RST_DATA_MODE;
    cfg.direct_mode_code = RST_DIRECT_MODE;
    cfg.hold_ticks = RST_HOLD_TICKS;
    cfg.pulse_ticks = RST_PULSE_TICKS;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part: hex mode, arcade on, short hold countdown
    nc = '0;
    nc.key_mode = MODE_HEX;
    nc.data_mode_code = 2'd1;
    nc.direct_mode_code = 2'd2;
    nc.arcade_enable = 1'b1;
    nc.hold_ticks = 16'd3;
    nc.pulse_ticks = 16'd2;
    program_regs(nc);
    // data mode, upper value bits set
    e = bare_event(KIND_SET_MODE); e.value = 8'hFD; enqueue(e);
    // lowest key, then a plain key up clears data ready
    e = bare_event(KIND_KEY_DOWN); e.hex_key = 1'b1; enqueue(e);
    enqueue(bare_event(KIND_KEY_UP));
    // shift plus highest key latches 0x1f
    e = bare_event(KIND_KEY_DOWN); e.shift_key = 1'b1; enqueue(e);
    e = bare_event(KIND_KEY_DOWN); e.hex_key = 1'b1; e.key_index = 4'hF; enqueue(e);
    enqueue(bare_event(KIND_READ_DATA));
    e = bare_event(KIND_KEY_UP); e.shift_key = 1'b1; enqueue(e);
    // preset extremes
    e = bare_event(KIND_PRESET); e.value = 8'hFF; enqueue(e);
    enqueue(bare_event(KIND_READ_DATA));
    enqueue(bare_event(KIND_PRESET));
    // held key: countdown runs out and the key is polled again
    e = bare_event(KIND_KEY_DOWN); e.hex_key = 1'b1; e.key_index = 4'h5; enqueue(e);
    repeat (4) begin
      e = bare_event(KIND_TICK); e.still_held = 1'b1; enqueue(e);
    end
    enqueue(bare_event(KIND_TICK));
    // arcade controls: every direction bit, both fire keys and coin
    e = bare_event(KIND_KEY_DOWN);
    e.coin_key = 1'b1; e.dir_mask = 8'hFF; e.fire_a_key = 1'b1; e.fire_b_key = 1'b1;
    enqueue(e);
    enqueue(bare_event(KIND_READ_COIN));
    e = bare_event(KIND_KEY_UP);
    e.dir_mask = 8'h0F; e.fire_a_key = 1'b1; e.fire_b_key = 1'b1;
    enqueue(e);
    enqueue(bare_event(KIND_READ_COIN));
    // direct mode sends the key out as dma
    e = bare_event(KIND_SET_MODE); e.value = 8'h02; enqueue(e);
    e = bare_event(KIND_KEY_DOWN); e.hex_key = 1'b1; e.key_index = 4'hA; enqueue(e);
    enqueue(bare_event(KIND_KEY_UP));
    // undefined kind with all fields set changes nothing
    e = '1; e.kind = KIND_UNUSED; enqueue(e);
    enqueue(bare_event(KIND_TICK));
    wait_drained();

    // random phases; keypad mode walks through all four codes including the
    // spare one, and a few phases pin the register extremes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      nc.key_mode = ph[1:0];
      nc.data_mode_code = 2'($urandom_range(0, 3));
      nc.direct_mode_code = 2'($urandom_range(0, 3));
      nc.arcade_enable = 1'($urandom_range(0, 1));
      nc.flag_invert = 3'($urandom_range(0, 7));
      nc.hold_ticks = 16'($urandom_range(0, 6));
      nc.pulse_ticks = 16'($urandom_range(0, 6));
      case (ph)
        1: begin
          nc.data_mode_code = 2'd0;
          nc.direct_mode_code = 2'd3;
          nc.arcade_enable = 1'b0;
          nc.flag_invert = 3'd0;
        end
        2: begin
          nc.data_mode_code = 2'd3;
          nc.direct_mode_code = 2'd0;
          nc.arcade_enable = 1'b1;
          nc.flag_invert = 3'd7;
        end
        3: begin
          nc.hold_ticks = 16'hFFFF;
          nc.pulse_ticks = 16'hFFFF;
        end
        4: nc.hold_ticks = 16'd0;
        6: nc.pulse_ticks = 16'd0;
        default: ;
      endcase
      program_regs(nc);
      start = queued;
      // mostly sessions, the rest fully random events
      while (queued - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          push_session();
        end else begin
          e = ITEM_W'($urandom);
          enqueue(e);
        end
      end
      wait_drained();
    end

    if (fail_count == 0 && results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[hex_keypad_data_ready_controller_top.f]
rtl/core/hkdr_pkg.sv
rtl/core/hkdr_cfg.sv
rtl/core/hkdr_engine.sv
rtl/core/hex_keypad_data_ready_controller_top.sv
verif/testbench.sv
